// ===== rtl/qkh_pkg.sv =====
// Shared types and constants for the quadrature knob decoder with button hold.
// Used by qkh_knob, qkh_button and quadrature_knob_with_hold; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qkh_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SELECTOR_MODE = 2'd0;
    localparam logic [1:0] REG_HOLD_MS       = 2'd1;
    localparam logic [1:0] REG_POSITION_MAX  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers
    localparam logic        SELECTOR_MODE_RESET = 1'b0;
    localparam logic [15:0] HOLD_MS_RESET       = 16'd1000;
    localparam logic [6:0]  POSITION_MAX_RESET  = 7'd126;

    // Step counter wraps to -1 once it leaves +/- this limit
    localparam logic signed [15:0] STEP_LIMIT_POS = 16'sd32000;
    localparam logic signed [15:0] STEP_LIMIT_NEG = -16'sd32000;

    localparam logic signed [7:0] POSITION_NONE = -8'sd1;

    typedef struct packed {
        logic        line_a;
        logic        line_b;
        logic        button_n;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic              moved;
        logic              clockwise;
        logic signed [7:0] knob_position;
        logic              pressed;
        logic              held;
    } result_t;

    // Encoder part of a result
    typedef struct packed {
        logic              moved;
        logic              clockwise;
        logic signed [7:0] knob_position;
    } knob_out_t;

    // Button part of a result
    typedef struct packed {
        logic pressed;
        logic held;
    } button_out_t;

endpackage

`default_nettype wire

// ===== rtl/quadrature_knob_with_hold.sv =====
// Top level of the quadrature knob decoder with button hold detection.
// Depends on qkh_pkg, qkh_knob and qkh_button.
//
// Usage:
//   sample_*  : one request per pin sample (A, B, active-low button, ms time).
//               Taken at a clock edge with sample_valid high, sample_stall low.
//   result_*  : exactly one result request per sample, in order: moved,
//               clockwise, knob_position (-1 = none), pressed, held.
//   cfg_*     : register writes (0 selector_mode, 1 hold_ms, 2 position_max),
//               taken when cfg_valid is high; cfg_ready is always high.
//               Other indexes are ignored. Write only while the block is idle.
// Pipeline: a sample goes into the input register on the accepting edge and its
//   result is loaded into the result register on the edge at which the input
//   stage advances, which a stalled result can hold off.
// Throughput: one sample per cycle while result_stall is low, set by the single input-to-result stage.
// Stall: while result_stall holds the result, one more sample can be taken
//   into the input register; sample_stall rises only when both are full.
// Reset: decoder state starts as line A low, button released, step count 0,
//   position -1; registers return to selector 0, hold 1000 ms, max 126.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_knob_with_hold (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output      logic                                sample_stall,
    input  wire qkh_pkg::sample_t                    sample,
    output      logic                                result_valid,
    input  wire logic                                result_stall,
    output      qkh_pkg::result_t                    result,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [qkh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [qkh_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic        selector_mode_reg;
    logic [15:0] hold_ms_reg;
    logic [6:0]  position_max_reg;

    // Input stage
    logic             s1_valid_reg;
    qkh_pkg::sample_t s1_reg;

    // Result stage
    logic             result_valid_reg;
    qkh_pkg::result_t result_reg;

    logic                 advance;   // input stage item moves to result stage
    qkh_pkg::knob_out_t   knob;
    qkh_pkg::button_out_t button;

    assign cfg_ready    = 1'b1;
    assign advance      = s1_valid_reg && !(result_valid_reg && result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selector_mode_reg <= qkh_pkg::SELECTOR_MODE_RESET;
            hold_ms_reg       <= qkh_pkg::HOLD_MS_RESET;
            position_max_reg  <= qkh_pkg::POSITION_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qkh_pkg::REG_SELECTOR_MODE: selector_mode_reg <= cfg_data[0];
                qkh_pkg::REG_HOLD_MS:       hold_ms_reg       <= cfg_data[15:0];
                qkh_pkg::REG_POSITION_MAX:  position_max_reg  <= cfg_data[6:0];
                default:                    ;
            endcase
        end
    end

    // Input register: refills whenever it is empty or draining this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            s1_reg <= sample;
        end
    end

    qkh_knob u_knob (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .line_a        (s1_reg.line_a),
        .line_b        (s1_reg.line_b),
        .selector_mode (selector_mode_reg),
        .position_max  (position_max_reg),
        .knob          (knob)
    );

    qkh_button u_button (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .button_n (s1_reg.button_n),
        .now_ms   (s1_reg.now_ms),
        .hold_ms  (hold_ms_reg),
        .button   (button)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.moved         <= knob.moved;
            result_reg.clockwise     <= knob.clockwise;
            result_reg.knob_position <= knob.knob_position;
            result_reg.pressed       <= button.pressed;
            result_reg.held          <= button.held;
        end
    end

`ifndef SYNTHESIS
    // Held can only be flagged while the button is down
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.held || result_reg.pressed))
        else $error("held flagged without press");

    // Position never drops below the none value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.knob_position >= qkh_pkg::POSITION_NONE))
        else $error("knob position below -1");

    // A sample waiting behind a stalled result is kept intact
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid_reg && result_stall)
            |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("input stage lost while result stalled");

    // A result only leaves the result register when it is taken or replaced
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== rtl/qkh_knob.sv =====
// Encoder half of the knob decoder: edge detect on A, step counter, position.
// Depends on qkh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qkh_knob (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              line_a,
    input  wire logic              line_b,
    input  wire logic              selector_mode,
    input  wire logic [6:0]        position_max,
    output qkh_pkg::knob_out_t     knob
);

    logic                last_a_reg, last_a_next;
    logic signed [15:0]  step_count_reg, step_count_next;
    logic signed [7:0]   position_reg, position_next;
    logic                last_dir_reg, last_dir_next;

    logic                edge_a;
    logic                cw;
    logic signed [15:0]  step_sum;
    logic                step_pos;
    logic signed [8:0]   pos_sum;
    logic signed [8:0]   pos_max_ext;

    always_comb
    begin
        edge_a      = line_a != last_a_reg;
        cw          = line_b != line_a;
        step_sum    = cw ? step_count_reg + 16'sd1 : step_count_reg - 16'sd1;
        step_pos    = !selector_mode || !step_sum[0];
        pos_max_ext = $signed({2'b00, position_max});
        pos_sum     = $signed({position_reg[7], position_reg});
        if (step_pos)
        begin
            pos_sum = cw ? pos_sum + 9'sd1 : pos_sum - 9'sd1;
        end
        if (pos_sum < -9'sd1)
        begin
            pos_sum = -9'sd1;
        end
        if (pos_sum > pos_max_ext)
        begin
            pos_sum = pos_max_ext;
        end

        last_a_next     = line_a;
        step_count_next = step_count_reg;
        position_next   = position_reg;
        last_dir_next   = last_dir_reg;
        if (edge_a)
        begin
            last_dir_next = cw;
            position_next = pos_sum[7:0];
            if (step_sum > qkh_pkg::STEP_LIMIT_POS || step_sum < qkh_pkg::STEP_LIMIT_NEG)
            begin
                step_count_next = -16'sd1;
            end
            else
            begin
                step_count_next = step_sum;
            end
        end

        knob.moved         = edge_a;
        knob.clockwise     = last_dir_next;
        knob.knob_position = position_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg     <= 1'b0;
            step_count_reg <= '0;
            position_reg   <= qkh_pkg::POSITION_NONE;
            last_dir_reg   <= 1'b0;
        end
        else if (advance)
        begin
            last_a_reg     <= last_a_next;
            step_count_reg <= step_count_next;
            position_reg   <= position_next;
            last_dir_reg   <= last_dir_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qkh_button.sv =====
// Button half of the knob decoder: press state, press timer and hold flag.
// Depends on qkh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qkh_button (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              button_n,
    input  wire logic [31:0]       now_ms,
    input  wire logic [15:0]       hold_ms,
    output qkh_pkg::button_out_t   button
);

    logic        state_reg, state_next;
    logic [31:0] press_time_reg, press_time_next;
    logic        held_reg, held_next;
    logic        btn_pressed;
    logic [31:0] elapsed;

    always_comb
    begin
        btn_pressed     = !button_n;
        elapsed         = now_ms - press_time_reg;   // wraps mod 2^32
        state_next      = state_reg;
        press_time_next = press_time_reg;
        held_next       = held_reg;
        if (btn_pressed != state_reg)
        begin
            state_next      = btn_pressed;
            press_time_next = now_ms;
            held_next       = 1'b0;
        end
        else if (state_reg && (elapsed > {16'd0, hold_ms}))
        begin
            held_next = 1'b1;
        end
        button.pressed = state_next;
        button.held    = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= 1'b0;
            press_time_reg <= '0;
            held_reg       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            press_time_reg <= press_time_next;
            held_reg       <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/qkh_scoreboard_pkg.sv =====
// Scoreboard for the quadrature knob decoder: decodes each accepted pin sample
// and checks the block's results in order. Depends on qkh_pkg.
`timescale 1ns / 1ps

package qkh_scoreboard_pkg;

    import qkh_pkg::*;

    class knob_scoreboard;
        // register copies
        bit          selector_mode;
        bit [15:0]   hold_ms;
        bit [6:0]    position_max;
        // decoder state
        bit          last_a;
        int          step_count;
        int          position;
        bit          last_cw;
        bit          button_down;
        bit [31:0]   press_ms;
        bit          held_flag;

        result_t     results_due[$];
        int          mismatches;
        int          checked;

        function new();
            selector_mode = SELECTOR_MODE_RESET;
            hold_ms       = HOLD_MS_RESET;
            position_max  = POSITION_MAX_RESET;
            last_a        = 1'b0;
            step_count    = 0;
            position      = -1;
            last_cw       = 1'b0;
            button_down   = 1'b0;
            press_ms      = '0;
            held_flag     = 1'b0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_SELECTOR_MODE: selector_mode = data[0];
                REG_HOLD_MS:       hold_ms       = data;
                REG_POSITION_MAX:  position_max  = data[6:0];
                default: ;
            endcase
        endfunction

        // Decode one pin sample and queue the result it must produce.
        function void decode_sample(sample_t s);
            result_t r;
            bit      cw;
            bit      now_down;
            r = '0;
            if (s.line_a != last_a) begin
                cw = (s.line_b != s.line_a);
                r.moved = 1'b1;
                last_cw = cw;
                step_count += cw ? 1 : -1;
                // selector mode: move only on even counts (low bit, so -3 is odd)
                if (!selector_mode || !step_count[0])
                    position += cw ? 1 : -1;
                // clamp applies on every edge, even without a step
                if (position < -1)
                    position = -1;
                if (position > int'(position_max))
                    position = int'(position_max);
                if (step_count < int'(STEP_LIMIT_NEG) || step_count > int'(STEP_LIMIT_POS))
                    step_count = -1;
            end
            last_a = s.line_a;

            now_down = !s.button_n;
            if (now_down != button_down) begin
                held_flag   = 1'b0;
                press_ms    = s.now_ms;
                button_down = now_down;
            end else if (button_down && !held_flag && (s.now_ms - press_ms) > {16'd0, hold_ms})
                held_flag = 1'b1;

            r.clockwise     = last_cw;
            r.knob_position = position[7:0];
            r.pressed       = button_down;
            r.held          = held_flag;
            results_due.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 30)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected", checked));
                return;
            end
            want = results_due.pop_front();
            if (got.moved !== want.moved)
                report_mismatch($sformatf("result %0d moved %b, want %b",
                                          checked, got.moved, want.moved));
            if (got.clockwise !== want.clockwise)
                report_mismatch($sformatf("result %0d clockwise %b, want %b",
                                          checked, got.clockwise, want.clockwise));
            if (got.knob_position !== want.knob_position)
                report_mismatch($sformatf("result %0d knob_position %0d, want %0d",
                                          checked, got.knob_position, want.knob_position));
            if (got.pressed !== want.pressed)
                report_mismatch($sformatf("result %0d pressed %b, want %b",
                                          checked, got.pressed, want.pressed));
            if (got.held !== want.held)
                report_mismatch($sformatf("result %0d held %b, want %b",
                                          checked, got.held, want.held));
            checked++;
        endtask
    endclass

endpackage

// ===== verif/tb_quadrature_knob_with_hold.sv =====
// Self-checking bench for quadrature_knob_with_hold: directed and random pin
// samples, register phases and stall pressure. Depends on qkh_pkg and qkh_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_quadrature_knob_with_hold;

    import qkh_pkg::*;
    import qkh_scoreboard_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    // index beyond the register list; the block must ignore it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    sample_t                sample_data  = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result_data;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    knob_scoreboard knob_sb = new();

    // Stimulus-side view of the pins and the millisecond clock
    bit        enc_a;
    bit        btn_n    = 1'b1;
    bit [31:0] clock_ms = '0;

    // Idle switches for each side, and a one-shot long hold-off of the receiver
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;
    int stall_burst = 0;
    int cycles      = 0;

    quadrature_knob_with_hold u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        while (cycles < LIMIT_CYCLES)
            @(posedge clk) cycles++;
        $display("tb: failure");
        $finish;
    end

    // Result monitor. Values read right after the edge are the pre-edge ones,
    // i.e. exactly what the handshake saw.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            knob_sb.check_result(result_data);
    end

    // Receiver: per result, stall for a random gap while recv_idle is set (or a long burst on request),
    // then keep stall low until a result is taken.
    initial
    begin
        int gap;
        forever
        begin
            gap = recv_idle ? $urandom_range(0, 9) : 0;
            if (stall_burst > 0)
            begin
                gap = stall_burst;
                stall_burst = 0;
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    function automatic sample_t pin_sample(bit a, bit b, bit btn, bit [31:0] t);
        sample_t s;
        s.line_a   = a;
        s.line_b   = b;
        s.button_n = btn;
        s.now_ms   = t;
        return s;
    endfunction

    // Offer one request and hold it until accepted. Valid stays high afterwards
    // so a back-to-back request never drops it within one time step.
    task automatic send_sample(sample_t s);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        knob_sb.decode_sample(s);
        enc_a = s.line_a;
    endtask

    // Stop offering and let every outstanding result drain, plus pipeline slack
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (knob_sb.results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers back to back (only while idle). Unused data bits
    // carry junk, and the unused index is hit too.
    task automatic program_regs(bit sel, bit [15:0] hold, bit [6:0] pmax);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  val [4];
        idx[0] = REG_SELECTOR_MODE; val[0] = {15'($urandom), sel};
        idx[1] = REG_HOLD_MS;       val[1] = hold;
        idx[2] = REG_POSITION_MAX;  val[2] = {9'($urandom), pmax};
        idx[3] = REG_UNUSED;        val[3] = 16'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            knob_sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // One-way spin, no gaps: drives the position into its clamps
    task automatic spin(bit cw, int edges);
        bit a;
        for (int i = 0; i < edges; i++)
        begin
            a = ~enc_a;
            clock_ms += 1;
            send_sample(pin_sample(a, cw ? ~a : a, btn_n, clock_ms));
        end
    endtask

    // Mostly clean quadrature with a running clock; some B-only changes and
    // some noise with arbitrary pins and timestamps.
    task automatic random_run(int count);
        int      roll;
        bit      a;
        bit      b;
        sample_t s;
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && i % 50 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            clock_ms += $urandom_range(0, int'(knob_sb.hold_ms) / 4 + 3);
            if ($urandom_range(0, 11) == 0)
                btn_n = ~btn_n;
            if (roll < 45)
            begin
                a = ~enc_a;
                b = ~a;
            end
            else if (roll < 80)
            begin
                a = ~enc_a;
                b = a;
            end
            else if (roll < 90)
            begin
                a = enc_a;
                b = 1'($urandom_range(0, 1));
            end
            else
            begin
                a = 1'($urandom_range(0, 1));
                b = 1'($urandom_range(0, 1));
            end
            s = pin_sample(a, b, btn_n, clock_ms);
            if (roll >= 90)
            begin
                s.button_n = 1'($urandom_range(0, 1));
                s.now_ms   = $urandom;
            end
            send_sample(s);
        end
    endtask

    initial
    begin
        bit [15:0] hold;
        bit [6:0]  pmax;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: selector off, hold 1000 ms, max 126
        send_sample(pin_sample(0, 0, 1, 0));              // no edge
        send_sample(pin_sample(1, 0, 1, 5));              // clockwise
        send_sample(pin_sample(0, 1, 1, 6));              // clockwise
        send_sample(pin_sample(1, 1, 1, 7));              // counter-clockwise
        send_sample(pin_sample(0, 0, 1, 8));              // back to -1
        send_sample(pin_sample(1, 1, 1, 9));              // held at -1 by clamp
        send_sample(pin_sample(1, 0, 0, 100));            // press, B-only change
        send_sample(pin_sample(1, 0, 0, 1100));           // exactly hold: not held
        send_sample(pin_sample(1, 0, 0, 1101));           // one past: held
        send_sample(pin_sample(0, 1, 1, 1102));           // release with an edge
        send_sample(pin_sample(0, 1, 0, 32'hFFFF_FF00));  // press near wrap
        send_sample(pin_sample(0, 1, 0, 32'h0000_0300));  // wrapped elapsed time
        send_sample(pin_sample(0, 1, 1, 32'hFFFF_FFFF));  // release

        // Selector mode, zero hold, max 0: odd/even steps incl. negative counts
        wait_idle();
        program_regs(1'b1, 16'd0, 7'd0);
        send_sample(pin_sample(1, 1, 1, 10));
        send_sample(pin_sample(0, 0, 1, 11));
        send_sample(pin_sample(1, 1, 1, 12));
        send_sample(pin_sample(0, 1, 1, 13));
        send_sample(pin_sample(1, 0, 1, 14));
        send_sample(pin_sample(0, 1, 1, 15));
        send_sample(pin_sample(0, 1, 0, 20));             // press
        send_sample(pin_sample(0, 1, 0, 20));             // zero elapsed: not held
        send_sample(pin_sample(0, 1, 0, 21));             // held

        // Clamp at both ends; max 127 is reached on the way up
        wait_idle();
        program_regs(1'b0, 16'hFFFF, 7'd127);
        btn_n     = 1'b1;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        spin(1'b0, 140);
        spin(1'b1, 260);

        // Lower the max under a position of 127: the next edge pulls it down, step or not
        wait_idle();
        program_regs(1'b1, 16'd1000, 7'd5);
        spin(1'b1, 2);

        // Random phases through assorted register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            case (ph)
                0:       begin hold = 16'd1000;  pmax = 7'd127; end
                1:       begin hold = 16'd0;     pmax = 7'd0;   end
                2:       begin hold = 16'hFFFF;  pmax = 7'd126; end
                3:       begin hold = 16'($urandom_range(1, 200)); pmax = 7'd1; end
                4:       begin hold = 16'($urandom); pmax = 7'($urandom_range(0, 127)); end
                default: begin hold = 16'd3;     pmax = 7'($urandom_range(0, 127)); end
            endcase
            program_regs(ph[0], hold, pmax);
            send_idle = 1'b1;
            recv_idle = 1'b1;
            if (ph == 0)
                clock_ms = 32'hFFFF_F000;   // run the clock through its wrap
            if (ph == 2)
            begin
                // Receiver holds off while requests keep coming: block fills up
                send_idle   = 1'b0;
                recv_idle   = 1'b0;
                stall_burst = 60;
                random_run(40);
            end
            random_run(90);
            if (ph == 3)
                wait_idle();                // sender pauses until fully drained
            random_run(90);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (knob_sb.results_due.size() != 0)
            knob_sb.report_mismatch($sformatf("%0d results never arrived",
                                              knob_sb.results_due.size()));
        if (knob_sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== quadrature_knob_with_hold.f =====
rtl/qkh_pkg.sv
rtl/qkh_knob.sv
rtl/qkh_button.sv
rtl/quadrature_knob_with_hold.sv
verif/qkh_scoreboard_pkg.sv
verif/tb_quadrature_knob_with_hold.sv
